// File: sv/sem_pkg.sv
`default_nettype none
package sem_pkg;

    localparam int MAX_LINE_PIXELS = 1024;
    localparam int MAX_FRAME_ROWS  = 4096;

    localparam int COL_W    = $clog2(MAX_LINE_PIXELS);
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int ROW_W    = $clog2(MAX_FRAME_ROWS + 2);
    localparam int GRAD_W   = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    // index 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] t_rgb;
    typedef logic [8:0][7:0] t_taps;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       flush_item;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic       frame_last;
    } t_edge_out;

    typedef struct packed {
        t_rgb top;
        t_rgb mid;
        t_rgb bot;
    } t_col;

    typedef struct packed {
        t_rgb top;
        t_rgb mid;
    } t_ls_word;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_mask;

    typedef struct packed {
        logic  produce;
        logic  last;
        t_mask mask;
    } t_ctrl;

    function automatic logic [7:0] sem_mag(input logic signed [GRAD_W-1:0] gx,
                                           input logic signed [GRAD_W-1:0] gy);
        logic [GRAD_W-1:0] ax;
        logic [GRAD_W-1:0] ay;
        logic [GRAD_W-1:0] sum;
        ax  = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
        ay  = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
        sum = ax + ay;
        if (sum[GRAD_W-1:1] > (GRAD_W-1)'(255)) begin
            return 8'd255;
        end
        return sum[8:1];
    endfunction

endpackage
`default_nettype wire

// File: sv/sem_line_store.sv
`default_nettype none
module sem_line_store (
    input  wire                          i_clk,
    input  wire                          i_rd_en,
    input  wire  [sem_pkg::COL_W-1:0]    i_rd_addr,
    output sem_pkg::t_ls_word            o_rd_data,
    input  wire                          i_wr_en,
    input  wire  [sem_pkg::COL_W-1:0]    i_wr_addr,
    input  sem_pkg::t_ls_word            i_wr_data
);
    import sem_pkg::*;

    // top line in the upper half of the word, middle line in the lower half
    t_ls_word r_mem [MAX_LINE_PIXELS];
    t_ls_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // bypass the word being written in the same cycle (single pixel rows)
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: sv/sem_col_cell.sv
`default_nettype none
module sem_col_cell (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_shift,
    input  sem_pkg::t_col i_col,
    output sem_pkg::t_col o_col
);
    import sem_pkg::*;

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule
`default_nettype wire

// File: sv/sem_grad.sv
`default_nettype none
module sem_grad (
    input  sem_pkg::t_taps                       i_taps,
    input  sem_pkg::t_mask                       i_mask,
    output logic signed [sem_pkg::GRAD_W-1:0]    o_gx,
    output logic signed [sem_pkg::GRAD_W-1:0]    o_gy
);
    import sem_pkg::*;

    logic [8:0]               use_tap;
    logic signed [GRAD_W-1:0] v [9];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                use_tap[i*3+j] = (i != 0 || i_mask.up) && (i != 2 || i_mask.down)
                              && (j != 0 || i_mask.left) && (j != 2 || i_mask.right);
            end
        end
        for (int t = 0; t < 9; t++) begin
            v[t] = use_tap[t] ? $signed({{(GRAD_W-8){1'b0}}, i_taps[t]}) : '0;
        end
    end

    assign o_gx = (v[2] + (v[5] <<< 1) + v[8]) - (v[0] + (v[3] <<< 1) + v[6]);
    assign o_gy = (v[6] + (v[7] <<< 1) + v[8]) - (v[0] + (v[1] <<< 1) + v[2]);

endmodule
`default_nettype wire

// File: sv/sobel_edge_magnitude_3x3_rgb_top.sv
`default_nettype none
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order. One word is
// accepted per clock and one result leaves per clock when nothing stalls; the
// rate is set by the single line memory, which is read for a pixel as it enters
// and written from the stage a register. A result belongs to the pixel accepted
// frame_width+1 words earlier, so the source appends frame_width+1 flush words
// after each frame; the first frame_width+1 words of a frame give no result.
// A word passes four register stages (line read, window, gradients, output).
// Neighbors outside the frame count as zero. Writing frame_width or
// frame_height restarts the frame; write them only while the block is idle.
module sobel_edge_magnitude_3x3_rgb_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    input  sem_pkg::t_pix_in                  i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output sem_pkg::t_edge_out                o_out_data,
    input  wire                               i_out_stall,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [sem_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [sem_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sem_pkg::*;

    logic [WIDTH_W-1:0]  r_w;
    logic [HEIGHT_W-1:0] r_h;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;

    logic       en;
    logic       in_acc;
    logic       cfg_acc;
    t_ctrl      ctrl;
    t_rgb       pix;
    logic       frame_end;
    logic [WIDTH_W-1:0] col_next;

    logic       r_a_valid;
    t_ctrl      r_a_ctrl;
    t_rgb       r_a_pix;
    logic [COL_W-1:0] r_a_addr;
    t_ls_word   rd_word;
    t_ls_word   wr_word;

    logic       r_b_valid;
    logic       r_b_last;
    t_mask      r_b_mask;
    t_col       win [3];
    t_col       new_col;
    t_taps      taps [3];
    logic signed [GRAD_W-1:0] gx [3];
    logic signed [GRAD_W-1:0] gy [3];

    logic       r_c_valid;
    logic       r_c_last;
    logic signed [GRAD_W-1:0] r_c_gx [3];
    logic signed [GRAD_W-1:0] r_c_gy [3];

    logic       r_out_valid;
    t_edge_out  r_out;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign in_acc      = i_in_valid && en;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;

    // position flags of the pixel centered in the window after this word
    always_comb begin
        frame_end = ({1'b0, r_row} == ({1'b0, r_h} + 1'b1)) && (r_col == '0);
        ctrl.produce = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col != '0));
        ctrl.last    = frame_end;
        if (r_col == '0) begin
            ctrl.mask.up   = r_row > ROW_W'(2);
            ctrl.mask.down = {1'b0, r_row} <= {1'b0, r_h};
            ctrl.mask.left = r_w > WIDTH_W'(1);
        end else begin
            ctrl.mask.up   = r_row > ROW_W'(1);
            ctrl.mask.down = {1'b0, r_row} < {1'b0, r_h};
            ctrl.mask.left = r_col > COL_W'(1);
        end
        ctrl.mask.right = r_col != '0;
        if (!i_in_data.flush_item && ({1'b0, r_row} < {1'b0, r_h})) begin
            pix[0] = i_in_data.pixel_red;
            pix[1] = i_in_data.pixel_green;
            pix[2] = i_in_data.pixel_blue;
        end else begin
            pix = '0;
        end
        col_next = WIDTH_W'(r_col) + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= WIDTH_RESET;
            r_h   <= HEIGHT_RESET;
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (i_cfg_data[WIDTH_W-1:0] == '0) begin
                        r_w <= WIDTH_W'(1);
                    end else if (i_cfg_data[WIDTH_W-1:0] > WIDTH_W'(MAX_LINE_PIXELS)) begin
                        r_w <= WIDTH_W'(MAX_LINE_PIXELS);
                    end else begin
                        r_w <= i_cfg_data[WIDTH_W-1:0];
                    end
                    r_col <= '0;
                    r_row <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    if (i_cfg_data[HEIGHT_W-1:0] == '0) begin
                        r_h <= HEIGHT_W'(1);
                    end else if (i_cfg_data[HEIGHT_W-1:0] > HEIGHT_W'(MAX_FRAME_ROWS)) begin
                        r_h <= HEIGHT_W'(MAX_FRAME_ROWS);
                    end else begin
                        r_h <= i_cfg_data[HEIGHT_W-1:0];
                    end
                    r_col <= '0;
                    r_row <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (col_next >= r_w) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= col_next[COL_W-1:0];
            end
        end
    end

    // stage a: line memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_ctrl <= ctrl;
            r_a_pix  <= pix;
            r_a_addr <= r_col;
        end
    end

    assign wr_word.top = rd_word.mid;
    assign wr_word.mid = r_a_pix;

    sem_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_word),
        .i_wr_en   (en && r_a_valid),
        .i_wr_addr (r_a_addr),
        .i_wr_data (wr_word)
    );

    // stage b: window of three column cells, newest on the right
    assign new_col.top = rd_word.top;
    assign new_col.mid = rd_word.mid;
    assign new_col.bot = r_a_pix;

    sem_col_cell u_cell_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (en && r_a_valid),
        .i_col   (new_col),
        .o_col   (win[2])
    );

    sem_col_cell u_cell_centre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (en && r_a_valid),
        .i_col   (win[2]),
        .o_col   (win[1])
    );

    sem_col_cell u_cell_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (en && r_a_valid),
        .i_col   (win[1]),
        .o_col   (win[0])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid && r_a_ctrl.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_a_valid) begin
            r_b_last <= r_a_ctrl.last;
            r_b_mask <= r_a_ctrl.mask;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < 3; j++) begin
                taps[ch][j]   = win[j].top[ch];
                taps[ch][3+j] = win[j].mid[ch];
                taps[ch][6+j] = win[j].bot[ch];
            end
        end
    end

    // stage c: per-channel gradients
    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        sem_grad u_grad (
            .i_taps (taps[ch]),
            .i_mask (r_b_mask),
            .o_gx   (gx[ch]),
            .o_gy   (gy[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_b_valid) begin
            r_c_last <= r_b_last;
            for (int ch = 0; ch < 3; ch++) begin
                r_c_gx[ch] <= gx[ch];
                r_c_gy[ch] <= gy[ch];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_c_valid) begin
            r_out.edge_red   <= sem_mag(r_c_gx[0], r_c_gy[0]);
            r_out.edge_green <= sem_mag(r_c_gx[1], r_c_gy[1]);
            r_out.edge_blue  <= sem_mag(r_c_gx[2], r_c_gy[2]);
            r_out.frame_last <= r_c_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < r_w)
        else $error("column counter beyond row width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_row} <= ({1'b0, r_h} + 1'b1))
        else $error("row counter beyond frame end");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT)
        |=> (r_col == '0) && (r_row == '0))
        else $error("frame not restarted after register write");

    a_stall_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall && !u_line_store.i_wr_en)
        else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire
